### design/min_heap_priority_queue_assert.svh
// Assertion macros shared by the priority queue checker.
// No dependencies; include by bare file name.
`ifndef MIN_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define MIN_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// Clocked assertion, switched off while reset is asserted
`define MHPQ_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define MHPQ_ASSERT_ANY(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/mhpq_pkg.sv
// Shared types and constants for the min-heap priority queue.
// No dependencies; used by the controller, datapath, top level and checker.
package mhpq_pkg;

    // Store geometry
    localparam int CAPACITY  = 256;
    localparam int KEY_WIDTH = 32;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int CHD_W     = IDX_W + 2;

    // Action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    // Status codes
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_EMPTY = 2'd1;
    localparam logic [1:0] STS_FULL  = 2'd2;

    // Channel payloads
    typedef struct packed {
        logic        action;
        logic [31:0] key_in;
    } t_in_item;

    typedef struct packed {
        logic [31:0] key_out;
        logic [8:0]  entry_count;
        logic [1:0]  status;
    } t_out_item;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        DP_NOP,
        DP_INS_START,
        DP_INS_FULL,
        DP_REM_EMPTY,
        DP_REM_READ,
        DP_REM_LOAD,
        DP_UP_READ,
        DP_UP_MOVE,
        DP_DOWN_READ,
        DP_DOWN_MOVE,
        DP_PLACE
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   load_out;
    } t_dp_cmd;

    // Datapath status seen by the controller
    typedef struct packed {
        logic empty;
        logic full;
        logic at_root;
        logic no_left;
        logic go_up;
        logic stop_down;
    } t_dp_stat;

endpackage

### design/mhpq_ram.sv
// Generic simple RAM: one write port, two read ports with registered data.
// No dependencies.
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr_b,
    output logic [WIDTH-1:0]           o_rdata_a,
    output logic [WIDTH-1:0]           o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

### design/mhpq_dp.sv
// Datapath of the priority queue: heap store, fill count, moving key,
// hole position, result and output registers. Depends on mhpq_pkg, mhpq_ram.
module mhpq_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mhpq_pkg::t_in_item  i_in_item,
    input  mhpq_pkg::t_dp_cmd   i_cmd,
    output mhpq_pkg::t_dp_stat  o_stat,
    output mhpq_pkg::t_out_item o_out_item
);

    logic [mhpq_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic [mhpq_pkg::IDX_W-1:0]     r_pos, n_pos;
    logic [mhpq_pkg::KEY_WIDTH-1:0] r_key, n_key;
    logic [mhpq_pkg::KEY_WIDTH-1:0] r_res_key, n_res_key;
    logic [1:0]                     r_res_sts, n_res_sts;
    mhpq_pkg::t_out_item            r_out_item, n_out_item;

    logic [mhpq_pkg::KEY_WIDTH-1:0] rd_a, rd_b, pick_val, wdata;
    logic [mhpq_pkg::IDX_W-1:0]     parent, last_idx, pick_idx, raddr_a, raddr_b;
    logic [mhpq_pkg::CHD_W-1:0]     lc, rc, cnt_ext;
    logic                           lc_ok, rc_ok, pick_right, we;

    // Heap addressing around the hole
    assign parent     = (r_pos - mhpq_pkg::IDX_W'(1)) >> 1;
    assign last_idx   = mhpq_pkg::IDX_W'(r_cnt - mhpq_pkg::CNT_W'(1));
    assign lc         = {1'b0, r_pos, 1'b1};
    assign rc         = lc + mhpq_pkg::CHD_W'(1);
    assign cnt_ext    = mhpq_pkg::CHD_W'(r_cnt);
    assign lc_ok      = lc < cnt_ext;
    assign rc_ok      = rc < cnt_ext;

    // Smaller child; right wins ties
    assign pick_right = rc_ok && (rd_b <= rd_a);
    assign pick_val   = pick_right ? rd_b : rd_a;
    assign pick_idx   = pick_right ? rc[mhpq_pkg::IDX_W-1:0] : lc[mhpq_pkg::IDX_W-1:0];

    // Status to controller
    assign o_stat.empty     = (r_cnt == '0);
    assign o_stat.full      = (r_cnt == mhpq_pkg::CNT_W'(mhpq_pkg::CAPACITY));
    assign o_stat.at_root   = (r_pos == '0);
    assign o_stat.no_left   = !lc_ok;
    assign o_stat.go_up     = (r_key <= rd_a);
    assign o_stat.stop_down = (r_key <= pick_val);

    // Read address selection
    always_comb begin
        raddr_a = '0;
        raddr_b = '0;
        case (i_cmd.op)
            mhpq_pkg::DP_REM_READ: begin
                raddr_b = last_idx;
            end
            mhpq_pkg::DP_UP_READ: begin
                raddr_a = parent;
            end
            mhpq_pkg::DP_DOWN_READ: begin
                raddr_a = lc[mhpq_pkg::IDX_W-1:0];
                raddr_b = rc[mhpq_pkg::IDX_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // Write into the hole and register updates
    always_comb begin
        we         = 1'b0;
        wdata      = r_key;
        n_cnt      = r_cnt;
        n_pos      = r_pos;
        n_key      = r_key;
        n_res_key  = r_res_key;
        n_res_sts  = r_res_sts;
        n_out_item = r_out_item;
        case (i_cmd.op)
            mhpq_pkg::DP_INS_START: begin
                n_key     = i_in_item.key_in[mhpq_pkg::KEY_WIDTH-1:0];
                n_pos     = r_cnt[mhpq_pkg::IDX_W-1:0];
                n_cnt     = r_cnt + mhpq_pkg::CNT_W'(1);
                n_res_key = '0;
                n_res_sts = mhpq_pkg::STS_OK;
            end
            mhpq_pkg::DP_INS_FULL: begin
                n_res_key = '0;
                n_res_sts = mhpq_pkg::STS_FULL;
            end
            mhpq_pkg::DP_REM_EMPTY: begin
                n_res_key = '0;
                n_res_sts = mhpq_pkg::STS_EMPTY;
            end
            mhpq_pkg::DP_REM_LOAD: begin
                n_res_key = rd_a;
                n_res_sts = mhpq_pkg::STS_OK;
                n_key     = rd_b;
                n_pos     = '0;
                n_cnt     = r_cnt - mhpq_pkg::CNT_W'(1);
            end
            mhpq_pkg::DP_UP_MOVE: begin
                we    = 1'b1;
                wdata = rd_a;
                n_pos = parent;
            end
            mhpq_pkg::DP_DOWN_MOVE: begin
                we    = 1'b1;
                wdata = pick_val;
                n_pos = pick_idx;
            end
            mhpq_pkg::DP_PLACE: begin
                we    = 1'b1;
                wdata = r_key;
            end
            default: begin
            end
        endcase
        if (i_cmd.load_out) begin
            n_out_item.key_out     = 32'(r_res_key);
            n_out_item.entry_count = 9'(r_cnt);
            n_out_item.status      = r_res_sts;
        end
    end

    // Fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_key      <= n_key;
        r_res_key  <= n_res_key;
        r_res_sts  <= n_res_sts;
        r_out_item <= n_out_item;
    end

    assign o_out_item = r_out_item;

    // Heap store
    mhpq_ram #(
        .WIDTH (mhpq_pkg::KEY_WIDTH),
        .DEPTH (mhpq_pkg::CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (r_pos),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

endmodule

### design/mhpq_ctrl.sv
// Controller of the priority queue: sequences insert and remove sifts and
// owns the output valid. Depends on mhpq_pkg.
module mhpq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_action,
    input  logic               i_out_stall,
    input  mhpq_pkg::t_dp_stat i_stat,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output mhpq_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_CHK,
        S_UP_CMP,
        S_REM_LOAD,
        S_DN_CHK,
        S_DN_CMP,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // Next state and datapath commands
    always_comb begin
        n_state        = r_state;
        n_out_valid    = r_out_valid && i_out_stall;
        o_cmd.op       = mhpq_pkg::DP_NOP;
        o_cmd.load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_action == mhpq_pkg::ACT_INSERT) begin
                        if (i_stat.full) begin
                            o_cmd.op = mhpq_pkg::DP_INS_FULL;
                            n_state  = S_DONE;
                        end else begin
                            o_cmd.op = mhpq_pkg::DP_INS_START;
                            n_state  = S_UP_CHK;
                        end
                    end else begin
                        if (i_stat.empty) begin
                            o_cmd.op = mhpq_pkg::DP_REM_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            o_cmd.op = mhpq_pkg::DP_REM_READ;
                            n_state  = S_REM_LOAD;
                        end
                    end
                end
            end
            // Sift up: read parent, then move it down or drop the key in
            S_UP_CHK: begin
                if (i_stat.at_root) begin
                    o_cmd.op = mhpq_pkg::DP_PLACE;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = mhpq_pkg::DP_UP_READ;
                    n_state  = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_stat.go_up) begin
                    o_cmd.op = mhpq_pkg::DP_UP_MOVE;
                    n_state  = S_UP_CHK;
                end else begin
                    o_cmd.op = mhpq_pkg::DP_PLACE;
                    n_state  = S_DONE;
                end
            end
            S_REM_LOAD: begin
                o_cmd.op = mhpq_pkg::DP_REM_LOAD;
                n_state  = S_DN_CHK;
            end
            // Sift down: read both children, then move the smaller up
            S_DN_CHK: begin
                if (i_stat.no_left) begin
                    o_cmd.op = mhpq_pkg::DP_PLACE;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = mhpq_pkg::DP_DOWN_READ;
                    n_state  = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                if (i_stat.stop_down) begin
                    o_cmd.op = mhpq_pkg::DP_PLACE;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = mhpq_pkg::DP_DOWN_MOVE;
                    n_state  = S_DN_CHK;
                end
            end
            // Hand result to the output register once it is free
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### design/min_heap_priority_queue.sv
// Min-heap priority queue: top level joining controller and datapath.
// Depends on mhpq_pkg, mhpq_ctrl, mhpq_dp.
//
// Input channel (i_in_valid / o_in_stall / i_in_item): action 0 inserts
// key_in, action 1 removes the minimum. Output channel (o_out_valid /
// i_out_stall / o_out_item): one result per item with the removed key
// (zero otherwise), the entry count after the operation and a status
// (ok, remove on empty, insert on full dropped).
// One item is worked on at a time; o_in_stall is high from the transfer
// until the result has been loaded into the output register.
// A refused operation goes straight to the result; an insert climbs one
// level per parent read and compare, and a remove descends one level per
// read of both children and compare. Each level takes a registered read
// of the heap store followed by the compare and write of that level. The
// next item can be taken in the cycle after the result is loaded.
// The output register holds a finished result while the receiver stalls,
// and the next item is taken as soon as that result has moved to it.
// Synchronous reset empties the queue; store contents are not cleared.
module min_heap_priority_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mhpq_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mhpq_pkg::t_out_item o_out_item
);

    mhpq_pkg::t_dp_cmd  cmd;
    mhpq_pkg::t_dp_stat stat;

    // Sequencer
    mhpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_in_item.action),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // Store and registers
    mhpq_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_item (o_out_item)
    );

endmodule

### design/mhpq_checker.sv
// Port-level checks for the min-heap priority queue, bound to the top level.
// Depends on mhpq_pkg and min_heap_priority_queue_assert.svh.
`include "min_heap_priority_queue_assert.svh"

module mhpq_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_stall,
    input logic                i_out_valid,
    input logic                i_out_stall,
    input mhpq_pkg::t_out_item i_out_item
);

    // Reset leaves the block idle and with no result pending
    `MHPQ_ASSERT_ANY(a_reset_idle, i_clk, !i_rst_n |=> (!i_out_valid && !i_in_stall), "not idle after reset")

    // A stalled result holds
    `MHPQ_ASSERT_RST(a_out_hold, i_clk, i_rst_n, (i_out_valid && i_out_stall) |=> (i_out_valid && $stable(i_out_item)), "stalled result changed")

    // One item in flight: input stalls right after a transfer
    `MHPQ_ASSERT_RST(a_one_in_flight, i_clk, i_rst_n, (i_in_valid && !i_in_stall) |=> i_in_stall, "input taken while busy")

    // Remove on empty reports nothing removed and an empty queue
    `MHPQ_ASSERT_RST(a_empty_result, i_clk, i_rst_n, (i_out_valid && (i_out_item.status == mhpq_pkg::STS_EMPTY)) |-> ((i_out_item.key_out == 32'd0) && (i_out_item.entry_count == 9'd0)), "bad empty result")

    // Dropped insert reports a full queue
    `MHPQ_ASSERT_RST(a_full_result, i_clk, i_rst_n, (i_out_valid && (i_out_item.status == mhpq_pkg::STS_FULL)) |-> ((i_out_item.key_out == 32'd0) && (i_out_item.entry_count == 9'(mhpq_pkg::CAPACITY))), "bad full result")

endmodule

bind min_heap_priority_queue mhpq_checker u_mhpq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_item  (o_out_item)
);
